[rtl/core/hbsl_pkg.sv]
// shared constants, command codes and controller/datapath handshake types
package hbsl_pkg;

  localparam int SYMBOLS_DEF     = 256;
  localparam int COUNT_WIDTH_DEF = 16;

  // fixed field widths of the channels
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int FREQ_W = 16;
  localparam int SIZE_W = 9;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic clear_counts;
    logic count_read;
    logic count_write;
    logic build_init;
    logic sym_read;
    logic load_cs;
    logic scan_issue;
    logic place;
    logic end_build;
    logic rank_read;
    logic cntsym_read;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_valid;
    cmd_t command;
    logic cs_zero;
    logic scan_last;
    logic sym_last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/hbsl_in_if.sv]
// input channel: command beat with byte and rank
interface hbsl_in_if import hbsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] rank;

  modport source (output valid, command, data_byte, rank, input ready);
  modport sink   (input valid, command, data_byte, rank, output ready);
endinterface

[rtl/core/hbsl_out_if.sv]
// output channel: one result beat per command
interface hbsl_out_if import hbsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol;
  logic [FREQ_W-1:0] frequency;
  logic [SIZE_W-1:0] list_size;
  logic              valid_res;

  modport source (output valid, symbol, frequency, list_size, valid_res, input ready);
  modport sink   (input valid, symbol, frequency, list_size, valid_res, output ready);
endinterface

[rtl/core/hbsl_ctrl.sv]
// command sequencer for the histogram and rank-sort datapath
module hbsl_ctrl import hbsl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE      = 14'd1,
    ST_DECODE    = 14'd2,
    ST_CLR       = 14'd4,
    ST_CNT_RD    = 14'd8,
    ST_CNT_WR    = 14'd16,
    ST_BLD_RDS   = 14'd32,
    ST_BLD_LOAD  = 14'd64,
    ST_BLD_SCAN  = 14'd128,
    ST_BLD_DRAIN = 14'd256,
    ST_BLD_PLACE = 14'd512,
    ST_BLD_END   = 14'd1024,
    ST_RD_SYM    = 14'd2048,
    ST_RD_CNT    = 14'd4096,
    ST_FINISH    = 14'd8192
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.item_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.command)
          CMD_CLEAR: state_next = ST_CLR;
          CMD_COUNT: state_next = ST_CNT_RD;
          CMD_BUILD: begin
            cmd.build_init = 1'b1;
            state_next     = ST_BLD_RDS;
          end
          CMD_READ:  state_next = ST_RD_SYM;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_CLR: begin
        cmd.clear_counts = 1'b1;
        state_next       = ST_FINISH;
      end
      ST_CNT_RD: begin
        cmd.count_read = 1'b1;
        state_next     = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd.count_write = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_BLD_RDS: begin
        cmd.sym_read = 1'b1;
        state_next   = ST_BLD_LOAD;
      end
      ST_BLD_LOAD: begin
        cmd.load_cs = 1'b1;
        state_next  = stat.cs_zero ? ST_BLD_PLACE : ST_BLD_SCAN;
      end
      ST_BLD_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) state_next = ST_BLD_DRAIN;
      end
      ST_BLD_DRAIN: begin
        state_next = ST_BLD_PLACE;
      end
      ST_BLD_PLACE: begin
        cmd.place  = 1'b1;
        state_next = stat.sym_last ? ST_BLD_END : ST_BLD_RDS;
      end
      ST_BLD_END: begin
        cmd.end_build = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_RD_SYM: begin
        cmd.rank_read = 1'b1;
        state_next    = ST_RD_CNT;
      end
      ST_RD_CNT: begin
        cmd.cntsym_read = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a count write always follows the read of the same entry
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.count_write |-> $past(cmd.count_read))
    else $error("count write without preceding read");

  // the result register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending beat");

  // after a result the sequencer takes new beats
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> cmd.take)
    else $error("not ready after result");

endmodule

[rtl/core/hbsl_dp.sv]
// count store, rank scan, sorted symbol store and result register
module hbsl_dp import hbsl_pkg::*; #(
  parameter int SYMBOLS     = SYMBOLS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  hbsl_in_if.sink   item,
  hbsl_out_if.source result
);

  localparam int SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CNT_W = $clog2(SYMBOLS + 1);
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYMBOLS - 1);

  // latched beat
  cmd_t              cmd_q;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] rank_q;

  // count store with per-entry valid bits
  logic [COUNT_WIDTH-1:0] cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0]     cnt_vld;
  logic [SYM_W-1:0]       a_addr;
  logic                   a_en;
  logic [COUNT_WIDTH-1:0] a_data, b_data, a_cnt, b_cnt;
  logic                   a_vld, b_vld;
  logic                   byte_ok, cnt_wr;
  logic [SYM_W-1:0]       waddr;

  // build state
  logic [SYM_W-1:0]       s, t, t_q, pos;
  logic [CNT_W-1:0]       n, sorted_size;
  logic [COUNT_WIDTH-1:0] cs;
  logic                   cmp_en, hit_lower;

  // sorted symbol store
  logic [SYM_W-1:0] srt_mem [SYMBOLS];
  logic [SYM_W-1:0] srt_q;

  // result
  logic              o_vld;
  logic [BYTE_W-1:0] o_sym;
  logic [FREQ_W-1:0] o_freq;
  logic [SIZE_W-1:0] o_size;
  logic              o_res;
  logic              rank_hit;
  logic [31:0]       a_cnt32;
  logic [FREQ_W-1:0] freq_sat;

  assign item.ready = cmd.take;

  // capture the beat
  always_ff @(posedge clk) begin
    if (cmd.take && item.valid) begin
      cmd_q  <= cmd_t'(item.command);
      byte_q <= item.data_byte;
      rank_q <= item.rank;
    end
  end

  // read port a address select
  always_comb begin
    a_en = cmd.count_read | cmd.sym_read | cmd.cntsym_read;
    if (cmd.count_read) begin
      a_addr = byte_q[SYM_W-1:0];
    end else if (cmd.sym_read) begin
      a_addr = s;
    end else begin
      a_addr = srt_q;
    end
  end

  // count store read ports
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_data <= cnt_mem[a_addr];
      a_vld  <= cnt_vld[a_addr];
    end
    if (cmd.scan_issue) begin
      b_data <= cnt_mem[t];
      b_vld  <= cnt_vld[t];
      t_q    <= t;
    end
  end

  assign a_cnt   = a_vld ? a_data : '0;
  assign b_cnt   = b_vld ? b_data : '0;
  assign byte_ok = ({1'b0, byte_q} < SIZE_W'(SYMBOLS));
  assign waddr   = byte_q[SYM_W-1:0];
  assign cnt_wr  = cmd.count_write && byte_ok && !(&a_cnt);

  // saturating increment write
  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[waddr] <= a_cnt + COUNT_WIDTH'(1);
    end
  end

  // valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_counts) begin
      cnt_vld <= '0;
    end else if (cnt_wr) begin
      cnt_vld[waddr] <= 1'b1;
    end
  end

  // entry t goes before symbol s
  assign hit_lower = (b_cnt != '0) && ((b_cnt < cs) || ((b_cnt == cs) && (t_q < s)));

  // build counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s           <= '0;
      t           <= '0;
      pos         <= '0;
      n           <= '0;
      sorted_size <= '0;
      cmp_en      <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_issue;
      if (cmd.build_init) begin
        s <= '0;
        n <= '0;
      end
      if (cmd.load_cs) begin
        t   <= '0;
        pos <= '0;
      end
      if (cmd.scan_issue) t <= t + SYM_W'(1);
      if (cmp_en && hit_lower) pos <= pos + SYM_W'(1);
      if (cmd.place) begin
        if (cs != '0) n <= n + CNT_W'(1);
        if (s != SYM_LAST) s <= s + SYM_W'(1);
      end
      if (cmd.end_build) sorted_size <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cs) cs <= a_cnt;
  end

  // sorted symbol store
  always_ff @(posedge clk) begin
    if (cmd.place && (cs != '0)) begin
      srt_mem[pos] <= s;
    end
    if (cmd.rank_read) begin
      srt_q <= srt_mem[rank_q[SYM_W-1:0]];
    end
  end

  // result forming
  assign rank_hit = (cmd_q == CMD_READ) && ({1'b0, rank_q} < SIZE_W'(sorted_size));
  assign a_cnt32  = 32'(a_cnt);
  assign freq_sat = (a_cnt32 > 32'(FREQ_MAX)) ? FREQ_MAX : a_cnt32[FREQ_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (cmd.load_out) begin
      o_vld <= 1'b1;
    end else if (result.ready) begin
      o_vld <= 1'b0;
    end
  end

  // list length is held with the beat so a later build cannot change it
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_sym  <= rank_hit ? BYTE_W'(srt_q) : '0;
      o_freq <= rank_hit ? freq_sat : '0;
      o_size <= SIZE_W'(sorted_size);
      o_res  <= rank_hit;
    end
  end

  assign result.valid     = o_vld;
  assign result.symbol    = o_sym;
  assign result.frequency = o_freq;
  assign result.list_size = o_size;
  assign result.valid_res = o_res;

  // status
  assign stat.item_valid = item.valid;
  assign stat.command    = cmd_q;
  assign stat.cs_zero    = (a_cnt == '0);
  assign stat.scan_last  = (t == SYM_LAST);
  assign stat.sym_last   = (s == SYM_LAST);
  assign stat.out_free   = !o_vld || result.ready;

  // list length stays within the symbol set
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    cmd.end_build |=> (sorted_size <= CNT_W'(SYMBOLS)))
    else $error("list size beyond symbol set");

  // a placed symbol never overflows the list count
  a_place_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && (cs != '0)) |-> (n < CNT_W'(SYMBOLS)))
    else $error("too many symbols placed");

  // a counted entry reads as valid afterwards
  a_cnt_valid: assert property (@(posedge clk) disable iff (rst)
    cnt_wr |=> cnt_vld[$past(waddr)])
    else $error("counted entry not marked valid");

endmodule

[rtl/core/byte_histogram_sorted_list_unit.sv]
// byte histogram with rank-sorted symbol list, top level
//
//  channel   dir  beat contents
//  item      in   command, data_byte, rank
//  result    out  symbol, frequency, list_size, valid_res
//
// one beat in at a time; clear passes decode, clear and finish; count passes decode, read, write and finish
// read passes decode, rank read, count read and finish; build reads and places each symbol, with a
//   scan of every symbol on the single count-store compare port for each listed symbol
// reset clears the count valid bits at once: no clearing pass
// a finished result waits in the output register; the next beat is taken meanwhile,
//   and its own result waits until that register is free
module byte_histogram_sorted_list_unit import hbsl_pkg::*; #(
  parameter int SYMBOLS     = SYMBOLS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hbsl_in_if.sink     item,
  hbsl_out_if.source  result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  hbsl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // storage and arithmetic
  hbsl_dp #(
    .SYMBOLS     (SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .result (result)
  );

endmodule

[tb/tb_top.sv]
// testbench for the byte histogram with rank-sorted symbol list
module tb_top;
  import hbsl_pkg::*;

  localparam int NSYM           = SYMBOLS_DEF;
  localparam int COUNT_W        = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int LONG_RUN       = 40;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int REPORT_LIMIT   = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [FREQ_W-1:0] frequency;
    logic [SIZE_W-1:0] list_size;
    logic              valid_res;
  } hist_result_t;

  // mirror of the histogram and ranked list, plus the queue of results still owed
  class hist_scoreboard;
    logic [COUNT_W-1:0] sym_count [NSYM];
    logic [BYTE_W-1:0]  ranked_sym [NSYM];
    int unsigned        ranked_len;
    hist_result_t       owed_results [$];
    int unsigned        errors, checked, builds, longest;

    function new();
      foreach (sym_count[i]) sym_count[i] = '0;
      foreach (ranked_sym[i]) ranked_sym[i] = '0;
      ranked_len = 0;
      errors     = 0;
      checked    = 0;
      builds     = 0;
      longest    = 0;
    endfunction

    // stable insertion in ascending count; ascending symbol order keeps ties by value
    function void rebuild_ranking();
      int n, p;
      n = 0;
      for (int s = 0; s < NSYM; s++) begin
        if (sym_count[s] != '0) begin
          p = n;
          while (p > 0 && sym_count[ranked_sym[p-1]] > sym_count[s]) begin
            ranked_sym[p] = ranked_sym[p-1];
            p--;
          end
          ranked_sym[p] = 8'(s);
          n++;
        end
      end
      ranked_len = n;
      builds++;
      if (n > longest) longest = n;
    endfunction

    function void note_command(cmd_t cmd, logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] r);
      hist_result_t     want;
      longint unsigned  c;
      logic [BYTE_W-1:0] s;
      want = '0;
      case (cmd)
        CMD_CLEAR: begin
          foreach (sym_count[i]) sym_count[i] = '0;
        end
        CMD_COUNT: begin
          if (b < NSYM && sym_count[b] != {COUNT_W{1'b1}})
            sym_count[b] = sym_count[b] + 1'b1;
        end
        CMD_BUILD: begin
          rebuild_ranking();
        end
        default: begin
          if (r < ranked_len && r < NSYM) begin
            s = ranked_sym[r];
            c = (s < NSYM) ? longint'(sym_count[s]) : 0;
            want.symbol    = s;
            want.frequency = (c > FREQ_MAX) ? FREQ_MAX : c[FREQ_W-1:0];
            want.valid_res = 1'b1;
          end
        end
      endcase
      want.list_size = ranked_len[SIZE_W-1:0];
      owed_results.push_back(want);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned seen);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    endfunction

    function void check_result(hist_result_t seen);
      hist_result_t want;
      checked++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, seen);
        return;
      end
      want = owed_results.pop_front();
      if (seen.symbol !== want.symbol) report("symbol", want.symbol, seen.symbol);
      if (seen.frequency !== want.frequency)
        report("frequency", want.frequency, seen.frequency);
      if (seen.list_size !== want.list_size)
        report("list_size", want.list_size, seen.list_size);
      if (seen.valid_res !== want.valid_res)
        report("valid_res", want.valid_res, seen.valid_res);
    endfunction
  endclass

  logic clk;
  logic rst;
  hbsl_in_if  in_ch ();
  hbsl_out_if out_ch ();

  hist_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    random_items;
  int unsigned    quiet_cycles;
  bit             in_gaps_on;
  bit             out_gaps_on;

  byte_histogram_sorted_list_unit #(
    .SYMBOLS     (NSYM),
    .COUNT_WIDTH (COUNT_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: note accepted commands, check result beats, count quiet cycles
  always @(posedge clk) begin : beat_monitor
    hist_result_t seen;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        sb.note_command(cmd_t'(in_ch.command), in_ch.data_byte, in_ch.rank);
      if (out_ch.valid && out_ch.ready) begin
        seen.symbol    = out_ch.symbol;
        seen.frequency = out_ch.frequency;
        seen.list_size = out_ch.list_size;
        seen.valid_res = out_ch.valid_res;
        sb.check_result(seen);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // result side: random stall before each beat
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = out_gaps_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  function automatic logic [BYTE_W-1:0] rnd8();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // one command beat; valid stays high across back-to-back beats
  task automatic send_item(cmd_t cmd, logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] r);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    in_ch.rank      <= r;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // clear (most of the time), count mostly from a small pool of symbols, build, then read ranks
  task automatic run_list_phase();
    logic [BYTE_W-1:0] pool [8];
    int pool_n, n_counts, n_reads, rounds;
    pool_n = $urandom_range(1, 8);
    for (int i = 0; i < pool_n; i++) pool[i] = rnd8();
    if ($urandom_range(0, 99) < 85) send_item(CMD_CLEAR, rnd8(), rnd8());
    n_counts = $urandom_range(3, 40);
    for (int i = 0; i < n_counts; i++)
      send_item(CMD_COUNT, ($urandom_range(0, 9) == 0) ? rnd8()
                           : pool[$urandom_range(0, pool_n - 1)], rnd8());
    rounds = ($urandom_range(0, 3) == 0) ? 2 : 1;
    for (int k = 0; k < rounds; k++) begin
      send_item(CMD_BUILD, rnd8(), rnd8());
      n_reads = $urandom_range(3, 16);
      for (int i = 0; i < n_reads; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_item(CMD_COUNT, pool[$urandom_range(0, pool_n - 1)], rnd8());
        else if ($urandom_range(0, 4) == 0)
          send_item(CMD_READ, rnd8(), rnd8());
        else
          send_item(CMD_READ, rnd8(), BYTE_W'($urandom_range(0, pool_n + 2)));
      end
    end
  endtask

  // unstructured commands, builds kept rare since each listed symbol is slow
  task automatic run_noise_phase();
    int n, pick;
    cmd_t cmd;
    n = $urandom_range(10, 30);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      cmd = CMD_CLEAR;
      else if (pick < 60) cmd = CMD_COUNT;
      else if (pick < 65) cmd = CMD_BUILD;
      else                cmd = CMD_READ;
      send_item(cmd, rnd8(), rnd8());
    end
  endtask

  // every symbol present: longest list, highest ranks
  task automatic run_full_phase();
    logic [BYTE_W-1:0] order [NSYM];
    logic [BYTE_W-1:0] tmp;
    int j;
    for (int i = 0; i < NSYM; i++) order[i] = 8'(i);
    for (int i = NSYM - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_item(CMD_CLEAR, rnd8(), rnd8());
    for (int i = 0; i < NSYM; i++) send_item(CMD_COUNT, order[i], rnd8());
    for (int i = 0; i < 60; i++) send_item(CMD_COUNT, rnd8(), rnd8());
    send_item(CMD_BUILD, rnd8(), rnd8());
    send_item(CMD_READ, rnd8(), 8'h00);
    send_item(CMD_READ, rnd8(), 8'hFF);
    for (int i = 0; i < 30; i++) send_item(CMD_READ, rnd8(), rnd8());
  endtask

  initial begin
    bit full_done;
    int base;
    sb              = new();
    items_sent      = 0;
    random_items    = 0;
    in_gaps_on      = 1'b1;
    out_gaps_on     = 1'b1;
    full_done       = 1'b0;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_CLEAR;
    in_ch.data_byte = '0;
    in_ch.rank      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // read and build on an empty store
    send_item(CMD_READ, 8'h00, 8'h00);
    send_item(CMD_BUILD, 8'hFF, 8'hFF);
    // extreme bytes, with a tie between 00 and 55
    send_item(CMD_COUNT, 8'h00, 8'hFF);
    send_item(CMD_COUNT, 8'hFF, 8'h00);
    send_item(CMD_COUNT, 8'h55, 8'hAA);
    send_item(CMD_COUNT, 8'hFF, 8'h00);
    send_item(CMD_BUILD, 8'h00, 8'h00);
    send_item(CMD_READ, 8'hFF, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h01);
    send_item(CMD_READ, 8'h00, 8'h02);
    // rank past the end
    send_item(CMD_READ, 8'h00, 8'h03);
    send_item(CMD_READ, 8'h00, 8'hFF);
    // counting after the build changes the count but not the order
    send_item(CMD_COUNT, 8'h00, 8'h00);
    send_item(CMD_COUNT, 8'h00, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00);
    // clear leaves the list, build after clear empties it
    send_item(CMD_CLEAR, 8'hFF, 8'hFF);
    send_item(CMD_READ, 8'h00, 8'h01);
    send_item(CMD_BUILD, 8'h00, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00);

    // one symbol counted many times, beats back to back with no gaps
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_item(CMD_CLEAR, 8'h00, 8'h00);
    for (int i = 0; i < LONG_RUN; i++) send_item(CMD_COUNT, 8'hA5, rnd8());
    send_item(CMD_BUILD, 8'h00, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00);
    send_item(CMD_COUNT, 8'h3C, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00);
    send_item(CMD_BUILD, 8'h00, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h01);

    // random phases, mostly well-formed lists
    base = items_sent;
    while (random_items < RANDOM_ITEMS) begin
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      if (!full_done && random_items > RANDOM_ITEMS / 2) begin
        run_full_phase();
        full_done = 1'b1;
      end else if ($urandom_range(0, 99) < 75) begin
        run_list_phase();
      end else begin
        run_noise_phase();
      end
      random_items = items_sent - base;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d command beats (%0d random), %0d result beats checked",
             items_sent, random_items, sb.checked);
    $display("%0d list builds, longest list %0d symbols, one long run on a single count",
             sb.builds, sb.longest);
    if (sb.errors == 0 && sb.owed_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
